[rtl/centered_fir_line_convolver_top_assert.svh]
// Assertion macros for the centered FIR line convolver
`ifndef CENTERED_FIR_LINE_CONVOLVER_TOP_ASSERT_SVH
`define CENTERED_FIR_LINE_CONVOLVER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define CFLC_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset
`define CFLC_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/cflc_pkg.sv]
// Shared constants and types of the centered FIR line convolver
`default_nettype none

package cflc_pkg;

    // Coefficient format and register layout
    localparam int TAP_BITS      = 16;
    localparam int TAPS_PER_REG  = 4;
    localparam int REG_TAPS      = 8;
    localparam int MAX_STUMP     = REG_TAPS / 2;
    localparam int KLEN_BITS     = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;
    localparam int COUNT_BITS    = 4;
    localparam int STUMP_BITS    = 3;
    localparam int LEFT_BITS     = 3;

    localparam logic [COUNT_BITS-1:0]    COUNT_MAX       = 4'd15;
    localparam logic [KLEN_BITS-1:0]     KLEN_RESET      = 4'd1;
    localparam logic [CFG_DATA_BITS-1:0] TAPS_LOW_RESET  = 64'd16384;
    localparam logic [CFG_DATA_BITS-1:0] TAPS_HIGH_RESET = 64'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KERNEL_LEN = 2'd0,
        REG_TAPS_LOW   = 2'd1,
        REG_TAPS_HIGH  = 2'd2
    } t_cfg_reg;

endpackage

`default_nettype wire

[rtl/centered_fir_line_convolver_top.sv]
// Centered FIR line convolver: same-mode convolution of one line with up to eight taps
//
// Usage: samples of one line enter on the input channel (i_in_valid / o_in_ready),
// the final sample flagged by i_last_in. Filtered words leave on the output
// channel (o_out_valid / i_out_ready), the final word of a line flagged by o_last_out.
// Kernel length and Q2.14 taps are written through i_cfg_we / i_cfg_idx / i_cfg_data
// while the block is idle; writes take effect at once.
// Path: an accepted input word loads the work register, and its result word then
// loads the output register once that register is free or its word is taken.
// Throughput: one input word per cycle for ordinary samples while the receiver takes
// each word, set by the single work register feeding the eight-way multiply and add
// tree. A word flagged last issues min(seen, stump) + 1 results, one per cycle while
// the receiver takes them, and the input is held off while the work register steps
// through the flush. The first stump words of a line produce no result unless last.
// Reset (synchronous, active low): delay line and sample count cleared, kernel
// length 1, tap 0 = 1.0, other taps 0, both pipeline registers empty.
// Receiver stall: the output register holds its word; the work register keeps
// its word too, so the input stalls only once both are full.
`default_nettype none

module centered_fir_line_convolver_top #(
    parameter int MAX_TAPS       = 8,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [cflc_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire logic [cflc_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]          i_sample_in,
    input  wire logic                                   i_last_in,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]               o_sample_out,
    output logic                                        o_saturated,
    output logic                                        o_last_out
);

`include "centered_fir_line_convolver_top_assert.svh"

    localparam int TB     = cflc_pkg::TAP_BITS;
    localparam int K_CAP  = (MAX_TAPS < cflc_pkg::REG_TAPS) ? MAX_TAPS : cflc_pkg::REG_TAPS;
    localparam int PROD_W = TB + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int V_W    = SUM_W + 1;
    localparam logic signed [V_W-1:0] HALF = V_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [V_W-1:0] SMAX = V_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [V_W-1:0] SMIN = -SMAX - V_W'(1);

    // Configuration registers
    logic [cflc_pkg::KLEN_BITS-1:0]     r_klen;
    logic [cflc_pkg::CFG_DATA_BITS-1:0] r_taps_low;
    logic [cflc_pkg::CFG_DATA_BITS-1:0] r_taps_high;

    // Line state
    logic signed [SAMPLE_BITS-1:0]      r_line [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]      n_line [MAX_TAPS];
    logic [cflc_pkg::COUNT_BITS-1:0]    r_seen, n_seen;

    // Work register
    logic                               r_wv, n_wv;
    logic signed [SAMPLE_BITS-1:0]      r_win [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]      n_win [MAX_TAPS];
    logic [cflc_pkg::LEFT_BITS-1:0]     r_left, n_left;
    logic                               r_wlast, n_wlast;

    // Output register
    logic                               r_ov, n_ov;
    logic signed [SAMPLE_BITS-1:0]      r_out, n_out;
    logic                               r_sat, n_sat;
    logic                               r_olast, n_olast;

    // Combinational signals
    logic [2*cflc_pkg::CFG_DATA_BITS-1:0] taps_all;
    logic signed [TB-1:0]               tap_raw [MAX_TAPS];
    logic signed [TB-1:0]               tap_eff [MAX_TAPS];
    logic [cflc_pkg::KLEN_BITS-1:0]     k_use;
    logic [cflc_pkg::STUMP_BITS-1:0]    stump;
    logic [cflc_pkg::STUMP_BITS-1:0]    d0;
    logic [cflc_pkg::LEFT_BITS-1:0]     left0;
    logic                               m_ge;
    logic                               emits;
    logic signed [SAMPLE_BITS-1:0]      sh [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]      win0 [MAX_TAPS];
    logic signed [PROD_W-1:0]           prod [MAX_TAPS];
    logic signed [SUM_W-1:0]            acc;
    logic signed [V_W-1:0]              v_rnd;
    logic signed [V_W-1:0]              rnd;
    logic signed [SAMPLE_BITS-1:0]      res;
    logic                               res_sat;
    logic                               out_ld;
    logic                               w_done;
    logic                               in_acc;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen      <= cflc_pkg::KLEN_RESET;
            r_taps_low  <= cflc_pkg::TAPS_LOW_RESET;
            r_taps_high <= cflc_pkg::TAPS_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cflc_pkg::REG_KERNEL_LEN: r_klen <= i_cfg_data[cflc_pkg::KLEN_BITS-1:0];
                cflc_pkg::REG_TAPS_LOW:   r_taps_low <= i_cfg_data;
                cflc_pkg::REG_TAPS_HIGH:  r_taps_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack taps; lanes past the register file read as zero
    assign taps_all = {r_taps_high, r_taps_low};

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_tap
        if (g < cflc_pkg::REG_TAPS) begin : g_reg
            assign tap_raw[g] = taps_all[g*TB +: TB];
        end else begin : g_zero
            assign tap_raw[g] = '0;
        end
    end

    // Clamp kernel length, mask unused taps
    always_comb begin
        k_use = ({1'b0, r_klen} > 5'(K_CAP)) ? 4'(K_CAP) : r_klen;
        stump = 3'(k_use >> 1);
        for (int t = 0; t < MAX_TAPS; t++) begin
            tap_eff[t] = (5'(t) < {1'b0, k_use}) ? tap_raw[t] : '0;
        end
    end

    // Handshake
    assign out_ld     = r_wv && (!r_ov || i_out_ready);
    assign w_done     = out_ld && (r_left == '0);
    assign o_in_ready = !r_wv || w_done;
    assign in_acc     = i_in_valid && o_in_ready;

    // Shift the new word in and work out the flush window
    always_comb begin
        sh[0] = i_sample_in;
        for (int i = 1; i < MAX_TAPS; i++) begin
            sh[i] = r_line[i-1];
        end
        m_ge  = (r_seen >= {1'b0, stump});
        emits = i_last_in || m_ge;
        d0    = m_ge ? '0 : (stump - 3'(r_seen));
        left0 = i_last_in ? (m_ge ? stump : 3'(r_seen)) : '0;
        // Pre-shift by the zero words that stand before the first flush output
        for (int i = 0; i < MAX_TAPS; i++) begin
            win0[i] = '0;
            for (int s = 0; s <= i && s <= cflc_pkg::MAX_STUMP; s++) begin
                if (3'(s) == d0) begin
                    win0[i] = sh[i-s];
                end
            end
        end
    end

    // Advance line state and sample count
    always_comb begin
        n_line = r_line;
        n_seen = r_seen;
        if (in_acc) begin
            if (i_last_in) begin
                for (int i = 0; i < MAX_TAPS; i++) begin
                    n_line[i] = '0;
                end
                n_seen = '0;
            end else begin
                n_line = sh;
                n_seen = (r_seen == cflc_pkg::COUNT_MAX) ? r_seen : r_seen + 1'b1;
            end
        end
    end

    // Load the work register, or step it through a flush
    always_comb begin
        n_wv    = r_wv;
        n_win   = r_win;
        n_left  = r_left;
        n_wlast = r_wlast;
        if (in_acc && emits) begin
            n_wv    = 1'b1;
            n_win   = win0;
            n_left  = left0;
            n_wlast = i_last_in;
        end else if (out_ld) begin
            if (r_left == '0) begin
                n_wv = 1'b0;
            end else begin
                n_win[0] = '0;
                for (int i = 1; i < MAX_TAPS; i++) begin
                    n_win[i] = r_win[i-1];
                end
                n_left = r_left - 1'b1;
            end
        end
    end

    // Multiply and sum, then round half up and saturate
    always_comb begin
        acc = '0;
        for (int h = 0; h < MAX_TAPS; h++) begin
            prod[h] = tap_eff[h] * r_win[h];
            acc     = acc + SUM_W'(prod[h]);
        end
        v_rnd = V_W'(acc) + HALF;
        rnd   = v_rnd >>> COEF_FRAC_BITS;
        if (rnd > SMAX) begin
            res     = SMAX[SAMPLE_BITS-1:0];
            res_sat = 1'b1;
        end else if (rnd < SMIN) begin
            res     = SMIN[SAMPLE_BITS-1:0];
            res_sat = 1'b1;
        end else begin
            res     = rnd[SAMPLE_BITS-1:0];
            res_sat = 1'b0;
        end
    end

    // Output register: load a word, or drop it once taken
    always_comb begin
        n_ov    = r_ov;
        n_out   = r_out;
        n_sat   = r_sat;
        n_olast = r_olast;
        if (out_ld) begin
            n_ov    = 1'b1;
            n_out   = res;
            n_sat   = res_sat;
            n_olast = r_wlast && (r_left == '0);
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_line[i] <= '0;
            end
            r_seen <= '0;
            r_wv   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_line <= n_line;
            r_seen <= n_seen;
            r_wv   <= n_wv;
            r_ov   <= n_ov;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_win   <= n_win;
        r_left  <= n_left;
        r_wlast <= n_wlast;
        r_out   <= n_out;
        r_sat   <= n_sat;
        r_olast <= n_olast;
    end

    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out;
    assign o_saturated  = r_sat;
    assign o_last_out   = r_olast;

    // Checks
    `CFLC_ASSERT_IMP(a_flush_blocks_input, r_wv && (r_left != '0), !o_in_ready,
        "input taken while a flush is still pending")
    `CFLC_ASSERT_IMP(a_multi_only_on_last, r_wv && (r_left != '0), r_wlast,
        "several results pending for a word not marked last")
    `CFLC_ASSERT_NXT(a_line_cleared, in_acc && i_last_in, (r_seen == '0) && (r_line[0] == '0),
        "line state not cleared after the last word")

endmodule

`default_nettype wire
